### sv/rational_number_alu_core_defines.svh
// Assertion macros shared by the rational ALU core.
`ifndef RATIONAL_NUMBER_ALU_CORE_DEFINES_SVH
`define RATIONAL_NUMBER_ALU_CORE_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define RNA_ASSERT_IMP(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define RNA_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");
`endif

### sv/rna_pkg.sv
// Package with types, codes and constants of the rational ALU core.
package rna_pkg;
    localparam int OPERAND_WIDTH = 32;
    localparam int W = 64;

    localparam logic [3:0] MODE_ADD = 4'd0;
    localparam logic [3:0] MODE_SUB = 4'd1;
    localparam logic [3:0] MODE_MUL = 4'd2;
    localparam logic [3:0] MODE_DIV = 4'd3;
    localparam logic [3:0] MODE_GT  = 4'd4;
    localparam logic [3:0] MODE_LT  = 4'd5;
    localparam logic [3:0] MODE_GE  = 4'd6;
    localparam logic [3:0] MODE_LE  = 4'd7;
    localparam logic [3:0] MODE_EQ  = 4'd8;
    localparam logic [3:0] MODE_NE  = 4'd9;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_ZERO = 2'd1;
    localparam logic [1:0] ERR_OVF  = 2'd2;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic signed [63:0] res_den;
        logic               compare_true;
        logic [1:0]         error;
    } t_out;

    // Command and status between the sequencer and the divider.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic [63:0] rem;
    } t_div_rsp;

    function automatic logic signed [63:0] op_value(input logic [31:0] raw);
        logic [OPERAND_WIDTH-1:0] v;
        v = raw[OPERAND_WIDTH-1:0];
        return {{(W-OPERAND_WIDTH){v[OPERAND_WIDTH-1]}}, v};
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : v;
    endfunction
endpackage

### sv/rational_number_alu_core.sv
// Rational ALU core: sequencer around one shared divider and one multiplier.
// Path, accepting edge to o_valid: bad denominators and unused modes go straight to S_OUT; mul
// and div run a gcd and two reducing divides; compares run a gcd, two lcm divides and a sum; add
// and sub add a second gcd and the two reducing divides. Each Euclid step is one divide plus handshake states.
// Throughput: one command at a time; busy falls in the o_valid cycle, which can accept again.
// Reset: synchronous active low, returns the sequencer to idle, no result; no receiver stall.
`include "rational_number_alu_core_defines.svh"
module rational_number_alu_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  rna_pkg::t_in  i_in,
    output logic          busy,
    output logic          o_valid,
    output rna_pkg::t_out o_out
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_MUL1  = 11'b00000000010,
        S_MUL2  = 11'b00000000100,
        S_GCD   = 11'b00000001000,
        S_GWAIT = 11'b00000010000,
        S_LCM   = 11'b00000100000,
        S_K     = 11'b00001000000,
        S_SUM   = 11'b00010000000,
        S_RN    = 11'b00100000000,
        S_RD    = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state r_state;
    rna_pkg::t_in r_in;
    logic signed [63:0] r_an, r_ad, r_bn, r_bd;
    logic signed [63:0] r_num, r_den;   // value to be reduced
    logic [63:0] r_gx, r_gy, r_g, r_lcm, r_k1;
    logic [1:0]  r_step;   // sub-step counter within a state
    logic        r_gcd_lcm; // gcd feeds the lcm rather than a reduction
    logic [63:0] r_mn;
    logic        r_valid;
    rna_pkg::t_out r_out;

    rna_pkg::t_div_req div_req;
    rna_pkg::t_div_rsp div_rsp;

    // Shared 33x33 signed multiplier: operands selected by state and step.
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic signed [64:0] sum;
    logic ovf;

    rna_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    always_comb begin
        mul_a = 33'(r_an);
        mul_b = 33'(r_bn);
        if (r_state == S_MUL1) begin
            if (r_in.mode == rna_pkg::MODE_MUL) begin
                mul_a = 33'(r_an); mul_b = 33'(r_bn);
            end else begin
                mul_a = 33'(r_an); mul_b = 33'(r_bd);
            end
        end else if (r_state == S_MUL2) begin
            if (r_in.mode == rna_pkg::MODE_MUL) begin
                mul_a = 33'(r_ad); mul_b = 33'(r_bd);
            end else begin
                mul_a = 33'(r_ad); mul_b = 33'(r_bn);
            end
        end else if (r_state == S_LCM) begin
            // The lcm is (mad / g) * mbd, and both factors fit in 32 bits.
            mul_a = 33'(div_rsp.quot);
            mul_b = 33'(rna_pkg::mag(r_bd));
        end else if (r_state == S_K) begin
            // k magnitudes fit in 32 bits; apply sign of the denominator later
            mul_a = (r_step == 2'd0) ? 33'(r_k1) : 33'(r_gx);
            mul_b = (r_step == 2'd0) ? 33'(r_an) : 33'(r_bn);
        end
    end

    assign sum = {r_num[63], r_num} + {r_den[63], r_den};
    assign ovf = sum[64] != sum[63];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            div_req.start <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            div_req.start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_in  <= i_in;
                        r_an  <= rna_pkg::op_value(i_in.a_num);
                        r_ad  <= rna_pkg::op_value(i_in.a_den);
                        r_bn  <= rna_pkg::op_value(i_in.b_num);
                        r_bd  <= rna_pkg::op_value(i_in.b_den);
                        r_step <= 2'd0;
                        r_out <= '{res_num: 64'sd0, res_den: 64'sd1,
                                   compare_true: 1'b0, error: rna_pkg::ERR_OK};
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    if (r_in.mode > rna_pkg::MODE_NE) begin
                        r_state <= S_OUT;
                    end else if (r_ad == 0 || r_bd == 0 ||
                                 (r_in.mode == rna_pkg::MODE_DIV && r_bn == 0)) begin
                        r_out.error <= rna_pkg::ERR_ZERO;
                        r_state <= S_OUT;
                    end else if (r_in.mode inside {rna_pkg::MODE_MUL, rna_pkg::MODE_DIV}) begin
                        r_num <= mul_p[63:0];
                        r_state <= S_MUL2;
                    end else begin
                        r_gx <= rna_pkg::mag(r_ad);
                        r_gy <= rna_pkg::mag(r_bd);
                        r_gcd_lcm <= 1'b1;
                        r_state <= S_GCD;
                    end
                end
                S_MUL2: begin
                    r_den <= mul_p[63:0];
                    r_gx <= rna_pkg::mag(r_num);
                    r_gy <= rna_pkg::mag(mul_p[63:0]);
                    r_gcd_lcm <= 1'b0;
                    r_state <= S_GCD;
                end
                S_GCD: begin
                    // Euclid: x, y <- y, x mod y until y is zero.
                    if (r_gy == 0) begin
                        r_g <= (r_gx == 0) ? 64'd1 : r_gx;
                        r_step <= 2'd0;
                        if (r_gcd_lcm) begin
                            div_req.dividend <= rna_pkg::mag(r_ad);
                            div_req.divisor  <= (r_gx == 0) ? 64'd1 : r_gx;
                            div_req.start <= 1'b1;
                            r_state <= S_LCM;
                        end else begin
                            div_req.dividend <= rna_pkg::mag(r_num);
                            div_req.divisor  <= (r_gx == 0) ? 64'd1 : r_gx;
                            div_req.start <= 1'b1;
                            r_state <= S_RN;
                        end
                    end else begin
                        div_req.dividend <= r_gx;
                        div_req.divisor  <= r_gy;
                        div_req.start <= 1'b1;
                        r_state <= S_GWAIT;
                    end
                end
                S_GWAIT: begin
                    if (div_rsp.done) begin
                        r_gx <= r_gy;
                        r_gy <= div_rsp.rem;
                        r_state <= S_GCD;
                    end
                end
                S_LCM: begin
                    // quotient mad/g is k2; lcm = k2*mbd, k1 = mbd/g
                    if (div_rsp.done) begin
                        if (r_step == 2'd0) begin
                            r_gx <= div_rsp.quot;  // k2 magnitude
                            r_lcm <= mul_p[63:0];
                            div_req.dividend <= rna_pkg::mag(r_bd);
                            div_req.divisor  <= r_g;
                            div_req.start <= 1'b1;
                            r_step <= 2'd1;
                        end else begin
                            r_k1 <= div_rsp.quot;
                            r_step <= 2'd0;
                            r_state <= S_K;
                        end
                    end
                end
                S_K: begin
                    if (r_step == 2'd0) begin
                        r_num <= r_ad[63] ? -mul_p[63:0] : mul_p[63:0];
                        r_step <= 2'd1;
                    end else begin
                        r_den <= (r_in.mode == rna_pkg::MODE_ADD) ?
                                 (r_bd[63] ? -mul_p[63:0] : mul_p[63:0]) :
                                 (r_bd[63] ? mul_p[63:0] : -mul_p[63:0]);
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (ovf) begin
                        r_out.error <= rna_pkg::ERR_OVF;
                        r_state <= S_OUT;
                    end else begin
                        case (r_in.mode)
                            rna_pkg::MODE_ADD, rna_pkg::MODE_SUB: begin
                                r_num <= sum[63:0];
                                r_den <= r_lcm;
                                r_gx <= rna_pkg::mag(sum[63:0]);
                                r_gy <= r_lcm;
                                r_gcd_lcm <= 1'b0;
                                r_state <= S_GCD;
                            end
                            rna_pkg::MODE_GT: r_out.compare_true <= !sum[63] && sum != 0;
                            rna_pkg::MODE_LT: r_out.compare_true <= sum[63];
                            rna_pkg::MODE_GE: r_out.compare_true <= !sum[63];
                            rna_pkg::MODE_LE: r_out.compare_true <= sum[63] || sum == 0;
                            rna_pkg::MODE_EQ: r_out.compare_true <= sum == 0;
                            default:          r_out.compare_true <= sum != 0;
                        endcase
                        if (!(r_in.mode inside {rna_pkg::MODE_ADD, rna_pkg::MODE_SUB}))
                            r_state <= S_OUT;
                    end
                end
                S_RN: begin
                    if (div_rsp.done) begin
                        r_mn <= div_rsp.quot;
                        div_req.dividend <= rna_pkg::mag(r_den);
                        div_req.divisor  <= r_g;
                        div_req.start <= 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (div_rsp.done) begin
                        r_out.res_num <= r_num[63] ? -r_mn : r_mn;
                        r_out.res_den <= r_den[63] ? -div_rsp.quot : div_rsp.quot;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_out   = r_out;

    `RNA_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `RNA_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    `RNA_ASSERT_IMP(a_err_clean, i_clk, i_rst_n, o_valid && o_out.error != rna_pkg::ERR_OK,
                    o_out.res_num == 0 && o_out.res_den == 1 && !o_out.compare_true)
endmodule

### sv/rna_divider.sv
// Radix-2 restoring divider for 64-bit unsigned values, one bit per cycle.
module rna_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rna_pkg::t_div_req i_req,
    output rna_pkg::t_div_rsp o_rsp
);
    logic        r_busy;
    logic [6:0]  r_cnt;
    logic [63:0] r_q;
    logic [63:0] r_r;
    logic [63:0] r_d;
    logic        r_done;
    logic [64:0] rem_sh;
    logic [64:0] diff;

    assign rem_sh = {r_r, r_q[63]};
    assign diff   = rem_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
                r_q    <= i_req.dividend;
                r_r    <= '0;
                r_d    <= i_req.divisor;
            end else if (r_busy) begin
                if (!diff[64]) begin
                    r_r <= diff[63:0];
                    r_q <= {r_q[62:0], 1'b1};
                end else begin
                    r_r <= rem_sh[63:0];
                    r_q <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_r;
endmodule

### bench/testbench.sv
// Self-checking bench for the rational ALU core: directed table, then random commands.
`timescale 1ns / 100ps
module testbench;
    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    rna_pkg::t_in   i_in = '0;
    logic           busy;
    logic           o_valid;
    rna_pkg::t_out  o_out;

    rational_number_alu_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_in(i_in),
        .busy(busy), .o_valid(o_valid), .o_out(o_out)
    );

    always #2 i_clk = ~i_clk;

    localparam int WATCHDOG = 50000;
    localparam int N_RANDOM = 1900;

    rna_pkg::t_out pending_results[$];
    int     fail_count = 0;
    int     results_seen = 0;
    int     idle_cycles = 0;
    int     cmds_sent = 0;

    function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic logic signed [63:0] sext(input logic [31:0] raw);
        logic [rna_pkg::OPERAND_WIDTH-1:0] v;
        v = raw[rna_pkg::OPERAND_WIDTH-1:0];
        return {{(64-rna_pkg::OPERAND_WIDTH){v[rna_pkg::OPERAND_WIDTH-1]}}, v};
    endfunction

    function automatic logic [63:0] absval(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic rna_pkg::t_out lowest_terms(input logic signed [63:0] num,
                                                   input logic signed [63:0] den);
        rna_pkg::t_out r;
        logic [63:0] mn, md, g;
        r = '0;
        mn = absval(num);
        md = absval(den);
        g = gcd64(mn, md);
        if (g == 0) g = 1;
        mn = mn / g;
        md = md / g;
        r.res_num = num[63] ? 64'(-mn) : mn;
        r.res_den = den[63] ? 64'(-md) : md;
        return r;
    endfunction

    function automatic rna_pkg::t_out fraction_result(input rna_pkg::t_in c);
        rna_pkg::t_out r;
        logic signed [63:0] an, ad, bn, bd, k1, k2, t1, t2, s;
        logic [63:0] mad, mbd, lcm;
        r = '0;
        r.res_den = 64'sd1;
        an = sext(c.a_num);
        ad = sext(c.a_den);
        bn = sext(c.b_num);
        bd = sext(c.b_den);
        if (c.mode > rna_pkg::MODE_NE) return r;
        if (ad == 0 || bd == 0 || (c.mode == rna_pkg::MODE_DIV && bn == 0)) begin
            r.error = rna_pkg::ERR_ZERO;
            return r;
        end
        if (c.mode == rna_pkg::MODE_MUL) return lowest_terms(an * bn, ad * bd);
        if (c.mode == rna_pkg::MODE_DIV) return lowest_terms(an * bd, ad * bn);
        mad = absval(ad);
        mbd = absval(bd);
        lcm = (mad / gcd64(mad, mbd)) * mbd;
        k1 = lcm / mad;
        k2 = lcm / mbd;
        if (ad < 0) k1 = -k1;
        if (bd < 0) k2 = -k2;
        t1 = k1 * an;
        t2 = k2 * bn;
        if (c.mode != rna_pkg::MODE_ADD) t2 = -t2;
        s = t1 + t2;
        if (t1[63] == t2[63] && s[63] != t1[63]) begin
            r.error = rna_pkg::ERR_OVF;
            return r;
        end
        case (c.mode)
            rna_pkg::MODE_ADD, rna_pkg::MODE_SUB: r = lowest_terms(s, lcm);
            rna_pkg::MODE_GT: r.compare_true = s > 0;
            rna_pkg::MODE_LT: r.compare_true = s < 0;
            rna_pkg::MODE_GE: r.compare_true = s >= 0;
            rna_pkg::MODE_LE: r.compare_true = s <= 0;
            rna_pkg::MODE_EQ: r.compare_true = s == 0;
            default: r.compare_true = s != 0;
        endcase
        return r;
    endfunction

    // Result checking; the receiver always takes the beat.
    always @(posedge i_clk) begin
        rna_pkg::t_out e;
        if (i_rst_n && o_valid) begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                $error("result beat with no command outstanding");
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_out.res_num !== e.res_num) begin
                    $error("res_num expected %0d actual %0d", e.res_num, o_out.res_num);
                    fail_count++;
                end
                if (o_out.res_den !== e.res_den) begin
                    $error("res_den expected %0d actual %0d", e.res_den, o_out.res_den);
                    fail_count++;
                end
                if (o_out.compare_true !== e.compare_true) begin
                    $error("compare_true expected %0b actual %0b",
                           e.compare_true, o_out.compare_true);
                    fail_count++;
                end
                if (o_out.error !== e.error) begin
                    $error("error expected %0d actual %0d", e.error, o_out.error);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog over cycles with neither a command nor a result accepted.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic issue(input rna_pkg::t_in c, input bit typed_in,
                         input rna_pkg::t_out typed_exp);
        i_in  <= c;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(typed_in ? typed_exp : fraction_result(c));
        cmds_sent++;
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000 + $urandom_range(0, 2);
            1: return 32'sh7fff_ffff - $urandom_range(0, 2);
            2: return $urandom_range(0, 40) - 20;
            3: return $urandom_range(0, 4000) - 2000;
            default: return $urandom;
        endcase
    endfunction

    typedef struct {
        rna_pkg::t_in  cmd;
        bit            typed;
        rna_pkg::t_out res;
    } t_row;

    localparam logic [31:0] MINV = 32'h8000_0000;
    localparam logic [31:0] MAXV = 32'h7fff_ffff;
    localparam rna_pkg::t_out ZERO_DEN = '{res_num: 64'sd0, res_den: 64'sd1,
                                           compare_true: 1'b0, error: rna_pkg::ERR_ZERO};
    localparam rna_pkg::t_out IGNORED = '{res_num: 64'sd0, res_den: 64'sd1,
                                          compare_true: 1'b0, error: rna_pkg::ERR_OK};

    t_row directed[] = '{
        '{'{rna_pkg::MODE_ADD, 32'd1, 32'd0, 32'd1, 32'd1}, 1'b1, ZERO_DEN},
        '{'{rna_pkg::MODE_GT, 32'd1, 32'd1, 32'd1, 32'd0}, 1'b1, ZERO_DEN},
        '{'{rna_pkg::MODE_DIV, 32'd3, 32'd4, 32'd0, 32'd5}, 1'b1, ZERO_DEN},
        '{'{4'd10, 32'd3, 32'd4, 32'd1, 32'd5}, 1'b1, IGNORED},
        '{'{4'd15, MAXV, MINV, MAXV, MINV}, 1'b1, IGNORED},
        '{'{rna_pkg::MODE_ADD, 32'd1, 32'd2, 32'd1, 32'd3}, 1'b0, IGNORED},
        '{'{rna_pkg::MODE_SUB, 32'd1, 32'd2, 32'd1, 32'd2}, 1'b0, IGNORED},
        '{'{rna_pkg::MODE_SUB, 32'd1, -32'sd2, 32'd1, 32'd2}, 1'b0, IGNORED},
        '{'{rna_pkg::MODE_MUL, 32'd0, -32'sd7, 32'd5, 32'd3}, 1'b0, IGNORED},
        '{'{rna_pkg::MODE_MUL, MINV, MINV, MINV, MAXV}, 1'b0, IGNORED},
        '{'{rna_pkg::MODE_DIV, MAXV, MINV, MINV, MAXV}, 1'b0, IGNORED},
        '{'{rna_pkg::MODE_ADD, MAXV, MINV, MAXV, MAXV}, 1'b0, IGNORED},
        '{'{rna_pkg::MODE_SUB, MINV, MAXV, MAXV, MINV}, 1'b0, IGNORED},
        '{'{rna_pkg::MODE_GT, 32'd1, 32'd2, 32'd1, 32'd3}, 1'b0, IGNORED},
        '{'{rna_pkg::MODE_LT, MINV, 32'd1, MAXV, 32'd1}, 1'b0, IGNORED},
        '{'{rna_pkg::MODE_GE, 32'd2, 32'd4, 32'd1, 32'd2}, 1'b0, IGNORED},
        '{'{rna_pkg::MODE_LE, 32'd3, -32'sd4, 32'd1, 32'd2}, 1'b0, IGNORED},
        '{'{rna_pkg::MODE_EQ, 32'd2, 32'd4, -32'sd1, -32'sd2}, 1'b0, IGNORED},
        '{'{rna_pkg::MODE_NE, MAXV, MAXV, MINV, MINV}, 1'b0, IGNORED},
        '{'{rna_pkg::MODE_DIV, -32'sd6, 32'd4, 32'd3, -32'sd8}, 1'b0, IGNORED}
    };

    initial begin
        rna_pkg::t_in c;
        int  burst;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i])
            issue(directed[i].cmd, directed[i].typed, directed[i].res);
        while (cmds_sent < directed.size() + N_RANDOM) begin
            // Sender bursts back to back, then sometimes pauses a random while.
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                c.mode  = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                       : 4'($urandom_range(0, 9));
                c.a_num = rand_operand();
                c.b_num = rand_operand();
                c.a_den = ($urandom_range(0, 30) == 0) ? 32'd0 : rand_operand();
                c.b_den = ($urandom_range(0, 30) == 0) ? 32'd0 : rand_operand();
                issue(c, 1'b0, IGNORED);
            end
            if ($urandom_range(0, 2) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 200)) @(posedge i_clk);
            end
        end
        @(posedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Ran %0d commands over all ten modes plus unused codes, %0d results checked.",
                 cmds_sent, results_seen);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
